### hw/rtl/rbb_pkg.sv
// Shared types, constants and arithmetic helpers for the RGBA blend / BGR row packer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rbb_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int LW_W       = 13;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int SUM_W      = 16;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int STEP_W     = 3;
    localparam int PADDR_W    = 5;

    // register indexes
    localparam logic [2:0] REG_LINE_WIDTH = 3'd0;
    localparam logic [2:0] REG_ALPHA_MODE = 3'd1;
    localparam logic [2:0] REG_BACK_RED   = 3'd2;
    localparam logic [2:0] REG_BACK_GREEN = 3'd3;
    localparam logic [2:0] REG_BACK_BLUE  = 3'd4;

    // byte positions within one pixel's run
    localparam logic [STEP_W-1:0] STEP_BLUE  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_GREEN = 3'd1;
    localparam logic [STEP_W-1:0] STEP_RED   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_LAST  = 3'd5;

    typedef struct packed {
        logic [LW_W-1:0] line_width;
        logic            alpha_mode;
        logic [7:0]      back_red;
        logic [7:0]      back_green;
        logic [7:0]      back_blue;
    } rbb_cfg_t;

    // one classified pixel: undivided blend sums and row-end info
    typedef struct packed {
        logic [SUM_W-1:0] sum_blue;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_red;
        logic             row_done;
        logic [1:0]       pad;
    } rbb_item_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } rbb_qctl_t;

    // back*(255-a) + chan*a, never above 65025
    function automatic logic [SUM_W-1:0] blend_sum(input logic [7:0] back,
                                                   input logic [7:0] chan,
                                                   input logic [7:0] alpha);
        logic [SUM_W-1:0] p_back;
        logic [SUM_W-1:0] p_chan;
        logic [7:0]       a_inv;
        a_inv  = 8'hFF - alpha;
        p_back = {8'd0, back} * {8'd0, a_inv};
        p_chan = {8'd0, chan} * {8'd0, alpha};
        return p_back + p_chan;
    endfunction

    // exact x/255 for x below 65280
    function automatic logic [7:0] div255(input logic [SUM_W-1:0] x);
        logic [SUM_W:0] t;
        t = {1'b0, x} + {9'd0, x[SUM_W-1:8]} + {{SUM_W{1'b0}}, 1'b1};
        return t[15:8];
    endfunction

endpackage

### hw/rtl/rbb_fifo.sv
// Two-entry queue of classified pixels between the front and back parts.
// Depends on rbb_pkg for the item type and depth.
`timescale 1ns / 1ps

module rbb_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rbb_pkg::rbb_item_t push_item,
    input  logic              pop,
    output rbb_pkg::rbb_item_t head_item,
    output logic              full,
    output logic              empty
);
    import rbb_pkg::*;

    rbb_item_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_CW-1:0]   count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full      = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hw/rtl/rbb_front.sv
// Front part: accepts pixels, tracks the row column, forms blend sums and padding info.
// Depends on rbb_pkg; feeds rbb_fifo.
`timescale 1ns / 1ps

module rbb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  rbb_pkg::rbb_cfg_t cfg,
    input  logic [7:0]        pix_red,
    input  logic [7:0]        pix_green,
    input  logic [7:0]        pix_blue,
    input  logic [7:0]        pix_alpha,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              q_full,
    output logic              q_push,
    output rbb_pkg::rbb_item_t q_item
);
    import rbb_pkg::*;

    logic [COL_W-1:0] column_count_reg;
    logic [COL_W-1:0] column_count_next;
    logic [LW_W-1:0]  eff_width;
    logic [LW_W-1:0]  col_plus;
    logic [7:0]       alpha_eff;
    logic             row_done;

    // three-channel mode blends at full opacity, which returns the channel unchanged
    assign alpha_eff = cfg.alpha_mode ? pix_alpha : 8'hFF;

    always_comb
    begin
        if (cfg.line_width == '0)
        begin
            eff_width = LW_W'(1);
        end
        else if (cfg.line_width > LW_W'(MAX_WIDTH))
        begin
            eff_width = LW_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = cfg.line_width;
        end
    end

    assign col_plus = {{(LW_W-COL_W){1'b0}}, column_count_reg} + LW_W'(1);
    assign row_done = (col_plus >= eff_width);

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.sum_blue  = blend_sum(cfg.back_blue, pix_blue, alpha_eff);
        q_item.sum_green = blend_sum(cfg.back_green, pix_green, alpha_eff);
        q_item.sum_red   = blend_sum(cfg.back_red, pix_red, alpha_eff);
        q_item.row_done  = row_done;
        q_item.pad       = row_done ? eff_width[1:0] : 2'd0;
    end

    assign column_count_next = row_done ? '0 : col_plus[COL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
        end
        else if (q_push)
        begin
            column_count_reg <= column_count_next;
        end
    end

endmodule

### hw/rtl/rbb_back.sv
// Back part: walks each queued pixel byte by byte (blue, green, red, padding) into
// the output register. Depends on rbb_pkg; drains rbb_fifo.
`timescale 1ns / 1ps

module rbb_back (
    input  logic               clk,
    input  logic               rst_n,
    input  rbb_pkg::rbb_item_t head_item,
    input  logic               q_empty,
    output logic               q_pop,
    output logic [7:0]         out_byte,
    output logic               run_last,
    output logic               row_end,
    output logic               out_valid,
    input  logic               out_ready
);
    import rbb_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [STEP_W-1:0] last_step;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              run_last_reg;
    logic              row_end_reg;
    logic              load;
    logic              at_last;
    logic [7:0]        byte_sel;

    assign load      = !q_empty && (!out_valid_reg || out_ready);
    assign last_step = STEP_RED + {1'b0, head_item.pad};
    assign at_last   = (step_reg == last_step);
    assign q_pop     = load && at_last;
    assign step_next = at_last ? STEP_BLUE : step_reg + 1'b1;

    always_comb
    begin
        case (step_reg)
            STEP_BLUE:  byte_sel = div255(head_item.sum_blue);
            STEP_GREEN: byte_sel = div255(head_item.sum_green);
            STEP_RED:   byte_sel = div255(head_item.sum_red);
            default:    byte_sel = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_BLUE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                step_reg <= step_next;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= byte_sel;
            run_last_reg <= at_last;
            row_end_reg  <= at_last && head_item.row_done;
        end
    end

    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign row_end   = row_end_reg;
    assign out_valid = out_valid_reg;

    // a padded row closes only on the last byte of a pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && row_end_reg |-> run_last_reg)
        else $error("row end without pixel run end");

    assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_LAST)
        else $error("byte step out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> step_reg == STEP_BLUE)
        else $error("step not rewound after pop");

    // padding bytes carry zero
    assert property (@(posedge clk) disable iff (!rst_n)
        load && step_reg > STEP_RED |=> out_byte_reg == 8'd0)
        else $error("nonzero padding byte");

endmodule

### hw/rtl/rgba_blend_to_padded_bgr_rows_top.sv
// Top level of the RGBA blend / BGR row packer: APB register file, front, queue, back.
// Depends on rbb_pkg, rbb_front, rbb_fifo and rbb_back.
`timescale 1ns / 1ps

// One pixel in, three bytes out (blue, green, red), one byte per clock while out_ready
// is high and the queue is not empty; after the last pixel of a row, (width mod 4) zero
// bytes follow so rows stay 4-byte aligned. The single byte-wide output register sets
// the output rate. The front accepts a pixel per cycle while the queue is not full, into
// a two-entry queue, so input and output stall independently. The first byte of a pixel
// passes through the queue and then the output register. Registers (APB, byte address 4*i):
// line_width, alpha_mode, back_red, back_green, back_blue; write them only while the block is idle.

module rgba_blend_to_padded_bgr_rows_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rbb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic [7:0]                  pix_red,
    input  logic [7:0]                  pix_green,
    input  logic [7:0]                  pix_blue,
    input  logic [7:0]                  pix_alpha,
    input  logic                        in_valid,
    output logic                        in_ready,
    output logic [7:0]                  out_byte,
    output logic                        run_last,
    output logic                        row_end,
    output logic                        out_valid,
    input  logic                        out_ready
);
    import rbb_pkg::*;

    rbb_cfg_t   cfg_reg;
    rbb_item_t  push_item;
    rbb_item_t  head_item;
    rbb_qctl_t  qctl;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_width <= LW_W'(1);
            cfg_reg.alpha_mode <= 1'b0;
            cfg_reg.back_red   <= 8'd0;
            cfg_reg.back_green <= 8'd0;
            cfg_reg.back_blue  <= 8'd0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_LINE_WIDTH: cfg_reg.line_width <= pwdata[LW_W-1:0];
                REG_ALPHA_MODE: cfg_reg.alpha_mode <= pwdata[0];
                REG_BACK_RED:   cfg_reg.back_red   <= pwdata[7:0];
                REG_BACK_GREEN: cfg_reg.back_green <= pwdata[7:0];
                REG_BACK_BLUE:  cfg_reg.back_blue  <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_LINE_WIDTH: prdata = {{(32-LW_W){1'b0}}, cfg_reg.line_width};
            REG_ALPHA_MODE: prdata = {31'd0, cfg_reg.alpha_mode};
            REG_BACK_RED:   prdata = {24'd0, cfg_reg.back_red};
            REG_BACK_GREEN: prdata = {24'd0, cfg_reg.back_green};
            REG_BACK_BLUE:  prdata = {24'd0, cfg_reg.back_blue};
            default:        prdata = 32'd0;
        endcase
    end

    rbb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pix_red   (pix_red),
        .pix_green (pix_green),
        .pix_blue  (pix_blue),
        .pix_alpha (pix_alpha),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .q_full    (qctl.full),
        .q_push    (qctl.push),
        .q_item    (push_item)
    );

    rbb_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (qctl.push),
        .push_item (push_item),
        .pop       (qctl.pop),
        .head_item (head_item),
        .full      (qctl.full),
        .empty     (qctl.empty)
    );

    rbb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_item (head_item),
        .q_empty   (qctl.empty),
        .q_pop     (qctl.pop),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .row_end   (row_end),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule
